// ----- hw/rtl/go_to_target_steering_assert.svh -----
// Assertion macros shared by the steering block.
`ifndef GO_TO_TARGET_STEERING_ASSERT_SVH
`define GO_TO_TARGET_STEERING_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GTTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GTTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/gtts_pkg.sv -----
// Shared types, constants and the arctangent table of the steering block.
`timescale 1ns / 1ps
package gtts_pkg;

   localparam int MAX_TARGETS = 16;

   // Field widths
   localparam int CSR_W       = 16;
   localparam int COUNT_W     = 5;
   localparam int COORD_W     = 16;
   localparam int LIN_W       = 12;
   localparam int ANG_W       = 15;
   localparam int DIST_W      = 16;
   localparam int HEAD_W      = 13;
   localparam int INDEX_OUT_W = 4;

   // Datapath widths
   localparam int CORDIC_W     = 32;
   localparam int ZACC_W       = 24;
   localparam int CORDIC_STEPS = 20;
   localparam int CORDIC_SCALE = 14;
   localparam int SQRT_W       = 32;
   localparam int SQRT_STEPS   = 16;
   localparam int SQRT_TOP     = 30;
   localparam int SQUARE_W     = 31;

   // Numeric constants (1/1024 units, angles in 2^-20 rad inside the chain)
   localparam int PI_Q20        = 3294199;
   localparam int HEADING_LIMIT = 3217;
   localparam int TURN_LIMIT    = 308;
   localparam int ONE_UNIT      = 1024;
   localparam int ROUND_HALF    = 512;
   localparam int ROUND_SHIFT   = 10;

   localparam logic [CSR_W-1:0]   THRESHOLD_RESET = 16'd1024;
   localparam logic [COUNT_W-1:0] COUNT_RESET     = 5'd1;

   // Register indexes
   localparam logic REG_SWITCH_THRESHOLD = 1'b0;
   localparam logic REG_TARGET_COUNT     = 1'b1;

   // Transaction opcodes
   localparam logic OP_POSE   = 1'b0;
   localparam logic OP_SWITCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SUM,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                       valid;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ZACC_W-1:0]   z;
   } cordic_lane_type;

   typedef struct packed {
      logic              valid;
      logic [SQRT_W-1:0] s;
      logic [SQRT_W-1:0] r;
   } sqrt_lane_type;

   // atan(2^-step) in 2^-20 rad
   function automatic logic signed [ZACC_W-1:0] atan_q20(input int step);
      logic signed [ZACC_W-1:0] a;
      case (step)
         0:       a = 24'sd823550;
         1:       a = 24'sd486170;
         2:       a = 24'sd256879;
         3:       a = 24'sd130396;
         4:       a = 24'sd65451;
         5:       a = 24'sd32757;
         6:       a = 24'sd16383;
         7:       a = 24'sd8192;
         8:       a = 24'sd4096;
         9:       a = 24'sd2048;
         10:      a = 24'sd1024;
         11:      a = 24'sd512;
         12:      a = 24'sd256;
         13:      a = 24'sd128;
         14:      a = 24'sd64;
         15:      a = 24'sd32;
         16:      a = 24'sd16;
         17:      a = 24'sd8;
         18:      a = 24'sd4;
         19:      a = 24'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- hw/rtl/gtts_cordic_cell.sv -----
// One vectoring CORDIC cell: a single micro-rotation, registered.
`timescale 1ns / 1ps
module gtts_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gtts_pkg::cordic_lane_type prev_lane,
   output gtts_pkg::cordic_lane_type next_lane
);

   localparam logic signed [gtts_pkg::ZACC_W-1:0] ATAN_STEP = gtts_pkg::atan_q20(STEP);

   gtts_pkg::cordic_lane_type lane_in;
   gtts_pkg::cordic_lane_type lane_ff;

   always_comb begin
      logic signed [gtts_pkg::CORDIC_W-1:0] x_cur;
      logic signed [gtts_pkg::CORDIC_W-1:0] y_cur;
      logic signed [gtts_pkg::CORDIC_W-1:0] dx;
      logic signed [gtts_pkg::CORDIC_W-1:0] dy;
      logic signed [gtts_pkg::ZACC_W-1:0]   z_cur;
      x_cur = prev_lane.x;
      y_cur = prev_lane.y;
      z_cur = prev_lane.z;
      dx = y_cur >>> STEP;
      dy = x_cur >>> STEP;
      lane_in.valid = prev_lane.valid;
      // rotate toward the x axis
      if (!y_cur[gtts_pkg::CORDIC_W-1]) begin
         lane_in.x = x_cur + dx;
         lane_in.y = y_cur - dy;
         lane_in.z = z_cur + ATAN_STEP;
      end else begin
         lane_in.x = x_cur - dx;
         lane_in.y = y_cur + dy;
         lane_in.z = z_cur - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

// ----- hw/rtl/gtts_sqrt_cell.sv -----
// One digit-by-digit square root cell: resolves one root bit, registered.
`timescale 1ns / 1ps
module gtts_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gtts_pkg::sqrt_lane_type prev_lane,
   output gtts_pkg::sqrt_lane_type next_lane
);

   localparam logic [gtts_pkg::SQRT_W-1:0] BIT_WEIGHT =
      gtts_pkg::SQRT_W'(1) << (gtts_pkg::SQRT_TOP - 2 * STEP);

   gtts_pkg::sqrt_lane_type lane_in;
   gtts_pkg::sqrt_lane_type lane_ff;

   always_comb begin
      logic [gtts_pkg::SQRT_W:0] trial;
      trial = {1'b0, prev_lane.r} + {1'b0, BIT_WEIGHT};
      lane_in.valid = prev_lane.valid;
      if ({1'b0, prev_lane.s} >= trial) begin
         lane_in.s = prev_lane.s - trial[gtts_pkg::SQRT_W-1:0];
         lane_in.r = (prev_lane.r >> 1) + BIT_WEIGHT;
      end else begin
         lane_in.s = prev_lane.s;
         lane_in.r = prev_lane.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

// ----- hw/rtl/go_to_target_steering.sv -----
// Top level of the go-to-target steering block: control, cell chains and result register.
`timescale 1ns / 1ps
`include "go_to_target_steering_assert.svh"
//
//  Channel | Dir | Handshake            | Contents
//  --------+-----+----------------------+-------------------------------------------
//  req_    | in  | req_valid / req_stall | op, rel_x, rel_y (one transaction per item)
//  rsp_    | out | rsp_valid / rsp_stall | cmd_valid, speeds, distance, heading, index
//  csr_    | in  | csr_write             | csr_index selects register, csr_data value
//
//  A pose update passes PREP and SUM and then waits until the 20-cell angle chain
//  ends; the 16-cell root chain runs beside it and ends earlier.
//  A manual switch waits only for the bit-serial remainder unit.
//  One transaction is in work at a time; a new one is taken while the result
//  register still holds the previous result.
//  Reset is synchronous and active high; it resets control state, the configuration
//  registers and the valid flags. A stalled result holds in the result register; the
//  core waits in FINISH for it.
module go_to_target_steering #(
   parameter int MAX_TARGETS = gtts_pkg::MAX_TARGETS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_op,
   input  logic signed [gtts_pkg::COORD_W-1:0]     req_rel_x,
   input  logic signed [gtts_pkg::COORD_W-1:0]     req_rel_y,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_cmd_valid,
   output logic [gtts_pkg::LIN_W-1:0]              rsp_linear_speed,
   output logic signed [gtts_pkg::ANG_W-1:0]       rsp_angular_speed,
   output logic [gtts_pkg::DIST_W-1:0]             rsp_distance,
   output logic signed [gtts_pkg::HEAD_W-1:0]      rsp_heading,
   output logic [gtts_pkg::INDEX_OUT_W-1:0]        rsp_target_index,
   output logic                                    rsp_reached,
   // configuration port
   input  logic                                    csr_write,
   input  logic                                    csr_index,
   input  logic [gtts_pkg::CSR_W-1:0]              csr_data
);

   // Index storage follows the largest target count; the remainder unit works
   // one bit wider so it holds the count itself and the incremented index.
   localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int NW    = IDX_W + 1;
   localparam int MC_W  = $clog2(NW + 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [gtts_pkg::CSR_W-1:0]   thr_ff, thr_in;
   logic [gtts_pkg::COUNT_W-1:0] tcount_ff, tcount_in;

   always_comb begin
      thr_in    = thr_ff;
      tcount_in = tcount_ff;
      if (csr_write) begin
         case (csr_index)
            gtts_pkg::REG_SWITCH_THRESHOLD: thr_in    = csr_data;
            gtts_pkg::REG_TARGET_COUNT:     tcount_in = csr_data[gtts_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= gtts_pkg::THRESHOLD_RESET;
         tcount_ff <= gtts_pkg::COUNT_RESET;
      end else begin
         thr_ff    <= thr_in;
         tcount_ff <= tcount_in;
      end
   end

   // Clamp the count to [1, MAX_TARGETS]
   logic [NW-1:0] eff_cnt;

   always_comb begin
      if (tcount_ff == '0) begin
         eff_cnt = NW'(1);
      end else if (int'(tcount_ff) > MAX_TARGETS) begin
         eff_cnt = NW'(MAX_TARGETS);
      end else begin
         eff_cnt = NW'(tcount_ff);
      end
   end

   // ------------------------------------------------------------------
   // Control state machine
   // ------------------------------------------------------------------
   gtts_pkg::state_type state_ff, state_in;

   logic req_accept;
   logic slot_free;
   logic prep_go;
   logic sum_go;
   logic finish_go;
   logic work_done;
   logic head_rdy_ff, head_rdy_in;
   logic op_ff;
   logic [MC_W-1:0] mod_cnt_ff, mod_cnt_in;

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid || !rsp_stall;
   assign work_done  = (mod_cnt_ff == '0) && ((op_ff == gtts_pkg::OP_SWITCH) || head_rdy_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gtts_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = gtts_pkg::ST_PREP;
            end
         end
         gtts_pkg::ST_PREP:   state_in = gtts_pkg::ST_SUM;
         gtts_pkg::ST_SUM:    state_in = gtts_pkg::ST_WAIT;
         gtts_pkg::ST_WAIT: begin
            if (work_done) begin
               state_in = gtts_pkg::ST_FINISH;
            end
         end
         gtts_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = gtts_pkg::ST_IDLE;
            end
         end
         default: state_in = gtts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      prep_go   = 1'b0;
      sum_go    = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         gtts_pkg::ST_IDLE:   req_stall = 1'b0;
         gtts_pkg::ST_PREP:   prep_go   = 1'b1;
         gtts_pkg::ST_SUM:    sum_go    = 1'b1;
         gtts_pkg::ST_WAIT:   ;
         gtts_pkg::ST_FINISH: finish_go = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Input capture
   // ------------------------------------------------------------------
   logic signed [gtts_pkg::COORD_W-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff <= req_op;
         x_ff  <= req_rel_x;
         y_ff  <= req_rel_y;
      end
   end

   // ------------------------------------------------------------------
   // Chain heads: squares for the root chain, folded vector for the angle chain
   // ------------------------------------------------------------------
   logic [gtts_pkg::SQUARE_W-1:0] sqx_ff, sqy_ff;
   logic                          zero_ff;
   gtts_pkg::cordic_lane_type     cordic_lane [gtts_pkg::CORDIC_STEPS+1];
   gtts_pkg::sqrt_lane_type       sqrt_lane [gtts_pkg::SQRT_STEPS+1];
   gtts_pkg::cordic_lane_type     cordic_head_in;
   gtts_pkg::sqrt_lane_type       sqrt_head_in;

   always_comb begin
      logic signed [gtts_pkg::COORD_W+1:0] xe;
      logic signed [gtts_pkg::COORD_W+1:0] ye;
      xe = (gtts_pkg::COORD_W+2)'(x_ff);
      ye = (gtts_pkg::COORD_W+2)'(y_ff);
      cordic_head_in.valid = prep_go && (op_ff == gtts_pkg::OP_POSE);
      cordic_head_in.z     = '0;
      // fold the left half plane by a half turn
      if (x_ff[gtts_pkg::COORD_W-1]) begin
         xe = -xe;
         ye = -ye;
         cordic_head_in.z = y_ff[gtts_pkg::COORD_W-1] ?
                            -gtts_pkg::ZACC_W'(gtts_pkg::PI_Q20) :
                            gtts_pkg::ZACC_W'(gtts_pkg::PI_Q20);
      end
      cordic_head_in.x = {xe, {gtts_pkg::CORDIC_SCALE{1'b0}}};
      cordic_head_in.y = {ye, {gtts_pkg::CORDIC_SCALE{1'b0}}};
   end

   always_comb begin
      sqrt_head_in.valid = sum_go && (op_ff == gtts_pkg::OP_POSE);
      sqrt_head_in.s     = gtts_pkg::SQRT_W'(sqx_ff) + gtts_pkg::SQRT_W'(sqy_ff);
      sqrt_head_in.r     = '0;
   end

   always_ff @(posedge clock) begin
      logic signed [2*gtts_pkg::COORD_W-1:0] px;
      logic signed [2*gtts_pkg::COORD_W-1:0] py;
      px = x_ff * x_ff;
      py = y_ff * y_ff;
      if (prep_go) begin
         sqx_ff  <= px[gtts_pkg::SQUARE_W-1:0];
         sqy_ff  <= py[gtts_pkg::SQUARE_W-1:0];
         zero_ff <= (x_ff == '0) && (y_ff == '0);
      end
      if (reset) begin
         cordic_lane[0] <= '0;
         sqrt_lane[0]   <= '0;
      end else begin
         cordic_lane[0] <= cordic_head_in;
         sqrt_lane[0]   <= sqrt_head_in;
      end
   end

   // ------------------------------------------------------------------
   // Cell chains
   // ------------------------------------------------------------------
   for (genvar i = 0; i < gtts_pkg::CORDIC_STEPS; i++) begin : g_cordic
      gtts_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_lane (cordic_lane[i]),
         .next_lane (cordic_lane[i+1])
      );
   end

   for (genvar k = 0; k < gtts_pkg::SQRT_STEPS; k++) begin : g_sqrt
      gtts_sqrt_cell #(
         .STEP (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_lane (sqrt_lane[k]),
         .next_lane (sqrt_lane[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Chain tails: rounded distance and rounded, clamped heading
   // ------------------------------------------------------------------
   logic [gtts_pkg::DIST_W-1:0]        dist_ff, dist_in;
   logic signed [gtts_pkg::HEAD_W-1:0] head_ff, head_in;

   always_comb begin
      gtts_pkg::sqrt_lane_type tail;
      tail    = sqrt_lane[gtts_pkg::SQRT_STEPS];
      // round to nearest: bump when the remainder exceeds the root
      dist_in = tail.r[gtts_pkg::DIST_W-1:0] + gtts_pkg::DIST_W'(tail.s > tail.r);
   end

   always_comb begin
      logic signed [gtts_pkg::ZACC_W-1:0] zf;
      logic [gtts_pkg::ZACC_W-1:0]        z_mag;
      logic [gtts_pkg::ZACC_W-1:0]        z_round;
      logic [gtts_pkg::ZACC_W-gtts_pkg::ROUND_SHIFT-1:0] h_raw;
      logic [gtts_pkg::HEAD_W-2:0]        h_mag;
      zf      = cordic_lane[gtts_pkg::CORDIC_STEPS].z;
      z_mag   = zf[gtts_pkg::ZACC_W-1] ? -zf : zf;
      z_round = z_mag + gtts_pkg::ZACC_W'(gtts_pkg::ROUND_HALF);
      h_raw   = z_round[gtts_pkg::ZACC_W-1:gtts_pkg::ROUND_SHIFT];
      if (h_raw > (gtts_pkg::ZACC_W-gtts_pkg::ROUND_SHIFT)'(gtts_pkg::HEADING_LIMIT)) begin
         h_mag = (gtts_pkg::HEAD_W-1)'(gtts_pkg::HEADING_LIMIT);
      end else begin
         h_mag = h_raw[gtts_pkg::HEAD_W-2:0];
      end
      if (zero_ff) begin
         head_in = '0;
      end else if (zf[gtts_pkg::ZACC_W-1]) begin
         head_in = -{1'b0, h_mag};
      end else begin
         head_in = {1'b0, h_mag};
      end
   end

   always_comb begin
      head_rdy_in = head_rdy_ff;
      if (req_accept) begin
         head_rdy_in = 1'b0;
      end else if (cordic_lane[gtts_pkg::CORDIC_STEPS].valid) begin
         head_rdy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sqrt_lane[gtts_pkg::SQRT_STEPS].valid) begin
         dist_ff <= dist_in;
      end
      if (cordic_lane[gtts_pkg::CORDIC_STEPS].valid) begin
         head_ff <= head_in;
      end
      if (reset) begin
         head_rdy_ff <= 1'b0;
      end else begin
         head_rdy_ff <= head_rdy_in;
      end
   end

   // ------------------------------------------------------------------
   // Remainder unit: (current index + 1) mod count, one bit a cycle
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [NW-1:0]    mod_dvd_ff, mod_dvd_in;
   logic [NW-1:0]    mod_rem_ff, mod_rem_in;

   always_comb begin
      logic [NW:0] rem_tmp;
      logic [NW:0] rem_sub;
      rem_tmp    = {mod_rem_ff, mod_dvd_ff[NW-1]};
      rem_sub    = rem_tmp - {1'b0, eff_cnt};
      mod_dvd_in = mod_dvd_ff;
      mod_rem_in = mod_rem_ff;
      mod_cnt_in = mod_cnt_ff;
      if (req_accept) begin
         mod_dvd_in = {1'b0, cur_ff} + NW'(1);
         mod_rem_in = '0;
         mod_cnt_in = MC_W'(NW);
      end else if (mod_cnt_ff != '0) begin
         mod_dvd_in = {mod_dvd_ff[NW-2:0], 1'b0};
         mod_rem_in = (rem_tmp >= {1'b0, eff_cnt}) ? rem_sub[NW-1:0] : rem_tmp[NW-1:0];
         mod_cnt_in = mod_cnt_ff - MC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      mod_dvd_ff <= mod_dvd_in;
      mod_rem_ff <= mod_rem_in;
      if (reset) begin
         mod_cnt_ff <= '0;
      end else begin
         mod_cnt_ff <= mod_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Steering decision and target index update
   // ------------------------------------------------------------------
   logic                               far;
   logic                               turn;
   logic                               advance;
   logic [gtts_pkg::HEAD_W-1:0]        head_abs;
   logic [gtts_pkg::LIN_W-2:0]         dist_cap;
   logic [IDX_W+gtts_pkg::INDEX_OUT_W-1:0] idx_wide;
   logic                               out_cmd_valid;
   logic [gtts_pkg::LIN_W-1:0]         out_lin;
   logic signed [gtts_pkg::ANG_W-1:0]  out_ang;
   logic [gtts_pkg::DIST_W-1:0]        out_dist;
   logic signed [gtts_pkg::HEAD_W-1:0] out_head;
   logic                               out_reached;

   assign far      = dist_ff > thr_ff;
   assign head_abs = head_ff[gtts_pkg::HEAD_W-1] ? -head_ff : head_ff;
   assign turn     = head_abs >= gtts_pkg::HEAD_W'(gtts_pkg::TURN_LIMIT);
   assign dist_cap = (dist_ff < gtts_pkg::DIST_W'(gtts_pkg::ONE_UNIT)) ?
                     dist_ff[gtts_pkg::LIN_W-2:0] : (gtts_pkg::LIN_W-1)'(gtts_pkg::ONE_UNIT);
   assign advance  = (op_ff == gtts_pkg::OP_SWITCH) || (!far && (eff_cnt > NW'(1)));
   assign cur_in   = advance ? mod_rem_ff[IDX_W-1:0] : cur_ff;
   assign idx_wide = {{gtts_pkg::INDEX_OUT_W{1'b0}}, cur_in};

   always_comb begin
      out_cmd_valid = 1'b0;
      out_lin       = '0;
      out_ang       = '0;
      out_dist      = '0;
      out_head      = '0;
      out_reached   = 1'b0;
      if (op_ff == gtts_pkg::OP_POSE) begin
         out_cmd_valid = 1'b1;
         out_dist      = dist_ff;
         out_head      = head_ff;
         if (far) begin
            out_ang = {head_ff, 2'b00};
            if (!turn) begin
               out_lin = {dist_cap, 1'b0};
            end
         end else begin
            out_reached = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (finish_go) begin
         cur_ff <= cur_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_cmd_valid_ff;
   logic [gtts_pkg::LIN_W-1:0]         rsp_lin_ff;
   logic signed [gtts_pkg::ANG_W-1:0]  rsp_ang_ff;
   logic [gtts_pkg::DIST_W-1:0]        rsp_dist_ff;
   logic signed [gtts_pkg::HEAD_W-1:0] rsp_head_ff;
   logic [gtts_pkg::INDEX_OUT_W-1:0]   rsp_index_ff;
   logic                               rsp_reached_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish_go) begin
         rsp_cmd_valid_ff <= out_cmd_valid;
         rsp_lin_ff       <= out_lin;
         rsp_ang_ff       <= out_ang;
         rsp_dist_ff      <= out_dist;
         rsp_head_ff      <= out_head;
         rsp_index_ff     <= idx_wide[gtts_pkg::INDEX_OUT_W-1:0];
         rsp_reached_ff   <= out_reached;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cmd_valid     = rsp_cmd_valid_ff;
   assign rsp_linear_speed  = rsp_lin_ff;
   assign rsp_angular_speed = rsp_ang_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_heading       = rsp_head_ff;
   assign rsp_target_index  = rsp_index_ff;
   assign rsp_reached       = rsp_reached_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // hold the target index everywhere but at the finishing step
   `GTTS_ASSERT_NEXT(a_index_hold, clock, reset, state_ff != gtts_pkg::ST_FINISH,
                     $stable(cur_ff), "target index moved outside finish")

   // a manual switch result carries no command or status
   `GTTS_ASSERT_IMPLY(a_switch_blank, clock, reset, rsp_valid && !rsp_cmd_valid,
                      rsp_distance == '0 && rsp_reached == 1'b0 && rsp_linear_speed == '0,
                      "switch result carries pose data")

   // a reached target means a full stop
   `GTTS_ASSERT_IMPLY(a_reached_stop, clock, reset, rsp_valid && rsp_reached,
                      rsp_linear_speed == '0 && rsp_angular_speed == '0,
                      "speed commanded at a reached target")

endmodule
